@@ rtl/m65enc_pkg.sv @@
package m65enc_pkg;

	// Addressing modes
	localparam logic [3:0] MD_ABS  = 4'd0;
	localparam logic [3:0] MD_ABSX = 4'd1;
	localparam logic [3:0] MD_ABSY = 4'd2;
	localparam logic [3:0] MD_IMPL = 4'd3;
	localparam logic [3:0] MD_IMM  = 4'd4;
	localparam logic [3:0] MD_INDX = 4'd5;
	localparam logic [3:0] MD_INDY = 4'd6;
	localparam logic [3:0] MD_IND  = 4'd7;
	localparam logic [3:0] MD_REL  = 4'd8;
	localparam logic [3:0] MD_ZP   = 4'd9;
	localparam logic [3:0] MD_ZPX  = 4'd10;
	localparam logic [3:0] MD_ZPY  = 4'd11;
	localparam logic [3:0] MD_IMMH = 4'd12;
	localparam logic [3:0] MD_IMML = 4'd13;

	// Mnemonics in table order
	localparam logic [5:0] MN_ADC = 6'd0,  MN_AND = 6'd1,  MN_ASL = 6'd2,  MN_BCC = 6'd3;
	localparam logic [5:0] MN_BCS = 6'd4,  MN_BEQ = 6'd5,  MN_BNE = 6'd6,  MN_BMI = 6'd7;
	localparam logic [5:0] MN_BPL = 6'd8,  MN_BVC = 6'd9,  MN_BVS = 6'd10, MN_BIT = 6'd11;
	localparam logic [5:0] MN_BRK = 6'd12, MN_CLC = 6'd13, MN_CLD = 6'd14, MN_CLI = 6'd15;
	localparam logic [5:0] MN_CLV = 6'd16, MN_CMP = 6'd17, MN_CPX = 6'd18, MN_CPY = 6'd19;
	localparam logic [5:0] MN_DEC = 6'd20, MN_DEX = 6'd21, MN_DEY = 6'd22, MN_EOR = 6'd23;
	localparam logic [5:0] MN_INC = 6'd24, MN_INX = 6'd25, MN_INY = 6'd26, MN_JMP = 6'd27;
	localparam logic [5:0] MN_JSR = 6'd28, MN_LDA = 6'd29, MN_LDX = 6'd30, MN_LDY = 6'd31;
	localparam logic [5:0] MN_LSR = 6'd32, MN_NOP = 6'd33, MN_ORA = 6'd34, MN_PHA = 6'd35;
	localparam logic [5:0] MN_PHP = 6'd36, MN_PLA = 6'd37, MN_PLP = 6'd38, MN_ROL = 6'd39;
	localparam logic [5:0] MN_ROR = 6'd40, MN_RTI = 6'd41, MN_RTS = 6'd42, MN_SBC = 6'd43;
	localparam logic [5:0] MN_SEC = 6'd44, MN_SED = 6'd45, MN_SEI = 6'd46, MN_STA = 6'd47;
	localparam logic [5:0] MN_STX = 6'd48, MN_STY = 6'd49, MN_TAX = 6'd50, MN_TAY = 6'd51;
	localparam logic [5:0] MN_TSX = 6'd52, MN_TXA = 6'd53, MN_TXS = 6'd54, MN_TYA = 6'd55;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_RANGE   = 2'd1;
	localparam logic [1:0] ERR_ILLEGAL = 2'd2;
	localparam logic [1:0] ERR_PAST64K = 2'd3;

	localparam logic [2:0] FIX_NONE   = 3'd0;
	localparam logic [2:0] FIX_HIGH   = 3'd1;
	localparam logic [2:0] FIX_LOW    = 3'd2;
	localparam logic [2:0] FIX_BYTE   = 3'd3;
	localparam logic [2:0] FIX_BRANCH = 3'd4;
	localparam logic [2:0] FIX_WORD   = 3'd5;

	localparam logic [7:0] NOP_BYTE = 8'hEA;

	typedef struct packed {
		logic [15:0] location;
		logic        value_defined;
		logic [31:0] operand_value;
		logic        zp_request;
		logic [3:0]  addr_mode;
		logic [5:0]  mnemonic;
	} instr_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
		logic [7:0] opc;
	} lk_t;

	// Stage 1 result: resolved encoding plus operand flags
	typedef struct packed {
		logic        legal;
		logic [3:0]  kind;
		logic [7:0]  opc;
		logic        def;
		logic [15:0] val;
		logic        byte_ok;
		logic [32:0] off;
		logic        loc_top1;
		logic        loc_top2;
	} dec_t;

	// Stage 2 result: bytes ready to emit
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
		logic [1:0]      err;
		logic [2:0]      fix;
	} emit_t;

	function automatic lk_t alu_op(logic [3:0] mode, logic [7:0] base, logic has_imm);
		lk_t r;
		r = '0;
		r.kind = mode;
		r.hit = 1'b1;
		case (mode)
			MD_IMM: begin
				r.opc = base | 8'h09;
				r.hit = has_imm;
			end
			MD_ABS:  r.opc = base | 8'h0D;
			MD_ZP:   r.opc = base | 8'h05;
			MD_INDX: r.opc = base | 8'h01;
			MD_INDY: r.opc = base | 8'h11;
			MD_ZPX:  r.opc = base | 8'h15;
			MD_ABSX: r.opc = base | 8'h1D;
			MD_ABSY: r.opc = base | 8'h19;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic lk_t rmw_op(logic [3:0] mode, logic [7:0] base, logic has_impl);
		lk_t r;
		r = '0;
		r.kind = mode;
		r.hit = 1'b1;
		case (mode)
			MD_ABS:  r.opc = base | 8'h0E;
			MD_ZP:   r.opc = base | 8'h06;
			MD_ZPX:  r.opc = base | 8'h16;
			MD_ABSX: r.opc = base | 8'h1E;
			MD_IMPL: begin
				r.opc = base | 8'h0A;
				r.hit = has_impl;
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic lk_t one_op(logic [3:0] mode, logic [3:0] want, logic [7:0] opc);
		lk_t r;
		r.kind = mode;
		r.opc = opc;
		r.hit = (mode == want);
		return r;
	endfunction

	function automatic lk_t pick2(logic [3:0] mode, logic [3:0] m0, logic [7:0] o0,
			logic [3:0] m1, logic [7:0] o1);
		lk_t r;
		r.kind = mode;
		r.hit = (mode == m0) || (mode == m1);
		r.opc = (mode == m0) ? o0 : o1;
		return r;
	endfunction

	// Opcode ROM: legal (mnemonic, mode) pairs; branches take abs or zp as rel
	function automatic lk_t rom_lookup(logic [5:0] mn, logic [3:0] mode);
		lk_t r;
		logic [7:0] bop;
		logic [7:0] iop;
		r = '0;
		r.kind = mode;
		bop = 8'h00;
		iop = 8'h00;
		case (mn)
			MN_ADC: r = alu_op(mode, 8'h60, 1'b1);
			MN_AND: r = alu_op(mode, 8'h20, 1'b1);
			MN_CMP: r = alu_op(mode, 8'hC0, 1'b1);
			MN_EOR: r = alu_op(mode, 8'h40, 1'b1);
			MN_ORA: r = alu_op(mode, 8'h00, 1'b1);
			MN_SBC: r = alu_op(mode, 8'hE0, 1'b1);
			MN_STA: r = alu_op(mode, 8'h80, 1'b0);
			MN_LDA: begin
				if (mode == MD_IMMH || mode == MD_IMML) begin
					r.hit = 1'b1;
					r.opc = 8'hA9;
				end else begin
					r = alu_op(mode, 8'hA0, 1'b1);
				end
			end
			MN_ASL: r = rmw_op(mode, 8'h00, 1'b1);
			MN_ROL: r = rmw_op(mode, 8'h20, 1'b1);
			MN_LSR: r = rmw_op(mode, 8'h40, 1'b1);
			MN_ROR: r = rmw_op(mode, 8'h60, 1'b1);
			MN_DEC: r = rmw_op(mode, 8'hC0, 1'b0);
			MN_INC: r = rmw_op(mode, 8'hE0, 1'b0);
			MN_BCC, MN_BCS, MN_BEQ, MN_BNE, MN_BMI, MN_BPL, MN_BVC, MN_BVS: begin
				case (mn)
					MN_BCC: bop = 8'h90;
					MN_BCS: bop = 8'hB0;
					MN_BEQ: bop = 8'hF0;
					MN_BNE: bop = 8'hD0;
					MN_BMI: bop = 8'h30;
					MN_BPL: bop = 8'h10;
					MN_BVC: bop = 8'h50;
					default: bop = 8'h70;
				endcase
				r.hit = (mode == MD_REL) || (mode == MD_ABS) || (mode == MD_ZP);
				r.kind = MD_REL;
				r.opc = bop;
			end
			MN_BIT: r = pick2(mode, MD_ABS, 8'h2C, MD_ZP, 8'h24);
			MN_JMP: r = pick2(mode, MD_ABS, 8'h4C, MD_IND, 8'h6C);
			MN_JSR: r = one_op(mode, MD_ABS, 8'h20);
			MN_CPX: begin
				r = pick2(mode, MD_ABS, 8'hEC, MD_ZP, 8'hE4);
				if (mode == MD_IMM) begin
					r.hit = 1'b1;
					r.opc = 8'hE0;
				end
			end
			MN_CPY: begin
				r = pick2(mode, MD_ABS, 8'hCC, MD_ZP, 8'hC4);
				if (mode == MD_IMM) begin
					r.hit = 1'b1;
					r.opc = 8'hC0;
				end
			end
			MN_LDX: begin
				r.hit = 1'b1;
				case (mode)
					MD_IMM, MD_IMMH, MD_IMML: r.opc = 8'hA2;
					MD_ABS:  r.opc = 8'hAE;
					MD_ZP:   r.opc = 8'hA6;
					MD_ABSY: r.opc = 8'hBE;
					MD_ZPY:  r.opc = 8'hB6;
					default: r.hit = 1'b0;
				endcase
			end
			MN_LDY: begin
				r.hit = 1'b1;
				case (mode)
					MD_IMM, MD_IMMH, MD_IMML: r.opc = 8'hA0;
					MD_ABS:  r.opc = 8'hAC;
					MD_ZP:   r.opc = 8'hA4;
					MD_ABSX: r.opc = 8'hBC;
					MD_ZPX:  r.opc = 8'hB4;
					default: r.hit = 1'b0;
				endcase
			end
			MN_STX: begin
				r = pick2(mode, MD_ABS, 8'h8E, MD_ZP, 8'h86);
				if (mode == MD_ZPY) begin
					r.hit = 1'b1;
					r.opc = 8'h96;
				end
			end
			MN_STY: begin
				r = pick2(mode, MD_ABS, 8'h8C, MD_ZP, 8'h84);
				if (mode == MD_ZPX) begin
					r.hit = 1'b1;
					r.opc = 8'h94;
				end
			end
			MN_BRK, MN_CLC, MN_CLD, MN_CLI, MN_CLV, MN_DEX, MN_DEY, MN_INX, MN_INY,
			MN_NOP, MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_RTI, MN_RTS, MN_SEC, MN_SED,
			MN_SEI, MN_TAX, MN_TAY, MN_TSX, MN_TXA, MN_TXS, MN_TYA: begin
				case (mn)
					MN_BRK: iop = 8'h00;
					MN_CLC: iop = 8'h18;
					MN_CLD: iop = 8'hD8;
					MN_CLI: iop = 8'h58;
					MN_CLV: iop = 8'hB8;
					MN_DEX: iop = 8'hCA;
					MN_DEY: iop = 8'h88;
					MN_INX: iop = 8'hE8;
					MN_INY: iop = 8'hC8;
					MN_NOP: iop = 8'hEA;
					MN_PHA: iop = 8'h48;
					MN_PHP: iop = 8'h08;
					MN_PLA: iop = 8'h68;
					MN_PLP: iop = 8'h28;
					MN_RTI: iop = 8'h40;
					MN_RTS: iop = 8'h60;
					MN_SEC: iop = 8'h38;
					MN_SED: iop = 8'hF8;
					MN_SEI: iop = 8'h78;
					MN_TAX: iop = 8'hAA;
					MN_TAY: iop = 8'hA8;
					MN_TSX: iop = 8'hBA;
					MN_TXA: iop = 8'h8A;
					MN_TXS: iop = 8'h9A;
					default: iop = 8'h98;
				endcase
				r = one_op(mode, MD_IMPL, iop);
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mos6502_instruction_encoder.sv @@
// 6502 instruction encoder. Each item on the slave side is one parsed
// instruction; the master side returns its object bytes one per item, opcode
// first and 16-bit operands little-endian, with tlast on the final byte and
// the error and fixup codes repeated on every byte. Three register stages
// (opcode ROM and operand flags, operand byte build, byte serializer) make
// up the pipeline. The serializer sends one byte per cycle while m_tready
// is high; an instruction has 1 to 3 bytes: implied
// forms 1, one-byte operands 2, word operands and illegal combinations 3.
// A new instruction is taken while the previous one is still being sent.
module mos6502_instruction_encoder
	import m65enc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mnemonic, addr_mode, zp_request, operand_value, value_defined, location
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_byte
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	// error_code, fixup_kind
	output logic [4:0]  m_tuser
);

	instr_t instr;
	dec_t   dec;
	emit_t  emit;
	logic   dec_valid;
	logic   dec_ready;
	logic   emit_valid;
	logic   emit_ready;

	assign instr = s_tdata[59:0];

	m65enc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (instr),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_data  (dec)
	);

	m65enc_operand u_operand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec),
		.out_valid (emit_valid),
		.out_ready (emit_ready),
		.out_data  (emit)
	);

	m65enc_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (emit_valid),
		.in_ready (emit_ready),
		.in_data  (emit),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/m65enc_decode.sv @@
module m65enc_decode
	import m65enc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  instr_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output dec_t   out_data
);

	logic       valid_s1;
	dec_t       data_s1;
	dec_t       nxt;
	lk_t        lk_d;
	lk_t        lk_z;
	logic [3:0] zp_mode;
	logic       zp_fit;
	logic       use_z;

	always_comb begin
		case (in_data.addr_mode)
			MD_ABS:  zp_mode = MD_ZP;
			MD_ABSX: zp_mode = MD_ZPX;
			default: zp_mode = MD_ZPY;
		endcase
		lk_d = rom_lookup(in_data.mnemonic, in_data.addr_mode);
		lk_z = rom_lookup(in_data.mnemonic, zp_mode);
		zp_fit = in_data.zp_request && in_data.value_defined
			&& (in_data.operand_value[31:8] == 24'd0);
		// shrink absolute forms when illegal as written or when asked and in range
		use_z = (!lk_d.hit || zp_fit) && (in_data.addr_mode <= MD_ABSY) && lk_z.hit;

		nxt.legal    = use_z || lk_d.hit;
		nxt.kind     = use_z ? lk_z.kind : lk_d.kind;
		nxt.opc      = use_z ? lk_z.opc : lk_d.opc;
		nxt.def      = in_data.value_defined;
		nxt.val      = in_data.operand_value[15:0];
		nxt.byte_ok  = (in_data.operand_value[31:8] == 24'd0)
			|| (in_data.operand_value[31:8] == 24'hFFFFFF);
		nxt.off      = {in_data.operand_value[31], in_data.operand_value}
			- {17'd0, in_data.location} - 33'd2;
		nxt.loc_top1 = (in_data.location == 16'hFFFF);
		nxt.loc_top2 = (in_data.location[15:1] == 15'h7FFF);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

@@ rtl/m65enc_operand.sv @@
module m65enc_operand
	import m65enc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  dec_t  in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output emit_t out_data
);

	logic  valid_s2;
	emit_t data_s2;
	emit_t nxt;
	logic  off_ok;
	logic  kind_sel;

	always_comb begin
		off_ok = (in_data.off[32:7] == 26'd0) || (in_data.off[32:7] == {26{1'b1}});
		kind_sel = in_data.kind == MD_IMMH;
		nxt.bytes    = '0;
		nxt.bytes[0] = in_data.opc;
		nxt.err      = ERR_NONE;
		nxt.fix      = FIX_NONE;
		nxt.n        = 2'd2;
		if (!in_data.legal) begin
			nxt.n     = 2'd3;
			nxt.bytes = {NOP_BYTE, NOP_BYTE, NOP_BYTE};
			nxt.err   = ERR_ILLEGAL;
		end else begin
			case (in_data.kind)
				MD_IMPL: nxt.n = 2'd1;
				MD_IMMH, MD_IMML: begin
					if (!in_data.def) begin
						nxt.fix = kind_sel ? FIX_HIGH : FIX_LOW;
					end else begin
						nxt.bytes[1] = kind_sel ? in_data.val[15:8] : in_data.val[7:0];
					end
				end
				MD_IMM, MD_INDX, MD_INDY, MD_ZP, MD_ZPX, MD_ZPY: begin
					if (!in_data.def) begin
						nxt.fix = FIX_BYTE;
					end else if (!in_data.byte_ok) begin
						nxt.err = ERR_RANGE;
					end else begin
						nxt.bytes[1] = in_data.val[7:0];
					end
				end
				MD_REL: begin
					if (!in_data.def) begin
						nxt.fix = FIX_BRANCH;
					end else if (!off_ok) begin
						nxt.err = ERR_RANGE;
					end else begin
						nxt.bytes[1] = in_data.off[7:0];
					end
				end
				default: begin
					nxt.n = 2'd3;
					if (!in_data.def) begin
						nxt.fix = FIX_WORD;
					end else begin
						nxt.bytes[1] = in_data.val[7:0];
						nxt.bytes[2] = in_data.val[15:8];
					end
				end
			endcase
		end
		// overrides any other error
		if ((nxt.n == 2'd2 && in_data.loc_top1) || (nxt.n == 2'd3 && in_data.loc_top2)) begin
			nxt.err = ERR_PAST64K;
		end
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

endmodule

@@ rtl/m65enc_serial.sv @@
module m65enc_serial
	import m65enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  emit_t      in_data,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [4:0] m_tuser
);

	logic       valid_s3;
	emit_t      data_s3;
	logic [1:0] idx_s3;
	logic       last;

	assign last     = idx_s3 == (data_s3.n - 2'd1);
	assign in_ready = !valid_s3 || (m_tready && last);

	always_comb begin
		case (idx_s3)
			2'd0:    m_tdata = data_s3.bytes[0];
			2'd1:    m_tdata = data_s3.bytes[1];
			default: m_tdata = data_s3.bytes[2];
		endcase
	end

	assign m_tvalid = valid_s3;
	assign m_tlast  = last;
	assign m_tuser  = {data_s3.fix, data_s3.err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			idx_s3   <= 2'd0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
			idx_s3   <= 2'd0;
		end else if (m_tready) begin
			// advance to the next byte of the held item
			idx_s3 <= idx_s3 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= in_data;
		end
	end

endmodule

@@ rtl/m65enc_checker.sv @@
module m65enc_checker
	import m65enc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic [4:0]  m_tuser
);

	// hold a stalled byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output byte changed");

	// bytes of one instruction follow without a gap and share codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
		else $error("instruction bytes split or codes changed");

	// illegal combination emits NOP bytes with no fixup
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == ERR_ILLEGAL |-> m_tdata == NOP_BYTE
			&& m_tuser[4:2] == FIX_NONE)
		else $error("illegal combination not encoded as NOP");

	// a fixup never comes with a range or illegal error
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4:2] != FIX_NONE |-> m_tuser[1:0] == ERR_NONE
			|| m_tuser[1:0] == ERR_PAST64K)
		else $error("fixup reported with operand error");

endmodule

bind mos6502_instruction_encoder m65enc_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

@@ sim/tb_mos6502_instruction_encoder.sv @@
`timescale 1ns / 100ps

module tb_mos6502_instruction_encoder;
	import m65enc_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [5:0] MN_BAD = 6'd63;
	localparam logic [3:0] MD_BAD = 4'd15;

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic [1:0] err;
		logic [2:0] fix;
	} obj_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// mnemonic, addr_mode, zp_request, operand_value, value_defined, location
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// code_byte
	logic [7:0]  m_tdata;
	logic        m_tlast;
	// error_code, fixup_kind
	logic [4:0]  m_tuser;

	// bit 8 marks a legal (mnemonic, mode) pair
	logic [8:0]  opcode_rom [64][16];
	obj_byte_t   code_bytes_q [$];
	int          mismatches = 0;
	int          bytes_seen = 0;
	int          cycles = 0;
	bit          idle_on = 1'b1;
	int          long_hold = 0;

	mos6502_instruction_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic put_op(input logic [5:0] mn, input logic [3:0] md, input logic [7:0] op);
		opcode_rom[mn][md] = {1'b1, op};
	endtask

	task automatic put_alu(input logic [5:0] mn, input int imm, input int abs_op, input int zp,
			input int indx, input int indy, input int zpx, input int absx, input int absy);
		if (imm >= 0) put_op(mn, MD_IMM, imm[7:0]);
		put_op(mn, MD_ABS, abs_op[7:0]);
		put_op(mn, MD_ZP, zp[7:0]);
		put_op(mn, MD_INDX, indx[7:0]);
		put_op(mn, MD_INDY, indy[7:0]);
		put_op(mn, MD_ZPX, zpx[7:0]);
		put_op(mn, MD_ABSX, absx[7:0]);
		put_op(mn, MD_ABSY, absy[7:0]);
	endtask

	task automatic put_rmw(input logic [5:0] mn, input int abs_op, input int zp, input int impl,
			input int zpx, input int absx);
		put_op(mn, MD_ABS, abs_op[7:0]);
		put_op(mn, MD_ZP, zp[7:0]);
		if (impl >= 0) put_op(mn, MD_IMPL, impl[7:0]);
		put_op(mn, MD_ZPX, zpx[7:0]);
		put_op(mn, MD_ABSX, absx[7:0]);
	endtask

	task automatic fill_opcode_rom();
		foreach (opcode_rom[i, j]) opcode_rom[i][j] = '0;
		put_alu(MN_ADC, 'h69, 'h6D, 'h65, 'h61, 'h71, 'h75, 'h7D, 'h79);
		put_alu(MN_AND, 'h29, 'h2D, 'h25, 'h21, 'h31, 'h35, 'h3D, 'h39);
		put_alu(MN_CMP, 'hC9, 'hCD, 'hC5, 'hC1, 'hD1, 'hD5, 'hDD, 'hD9);
		put_alu(MN_EOR, 'h49, 'h4D, 'h45, 'h41, 'h51, 'h55, 'h5D, 'h59);
		put_alu(MN_LDA, 'hA9, 'hAD, 'hA5, 'hA1, 'hB1, 'hB5, 'hBD, 'hB9);
		put_alu(MN_ORA, 'h09, 'h0D, 'h05, 'h01, 'h11, 'h15, 'h1D, 'h19);
		put_alu(MN_SBC, 'hE9, 'hED, 'hE5, 'hE1, 'hF1, 'hF5, 'hFD, 'hF9);
		put_alu(MN_STA, -1, 'h8D, 'h85, 'h81, 'h91, 'h95, 'h9D, 'h99);
		put_rmw(MN_ASL, 'h0E, 'h06, 'h0A, 'h16, 'h1E);
		put_rmw(MN_ROL, 'h2E, 'h26, 'h2A, 'h36, 'h3E);
		put_rmw(MN_LSR, 'h4E, 'h46, 'h4A, 'h56, 'h5E);
		put_rmw(MN_ROR, 'h6E, 'h66, 'h6A, 'h76, 'h7E);
		put_rmw(MN_DEC, 'hCE, 'hC6, -1, 'hD6, 'hDE);
		put_rmw(MN_INC, 'hEE, 'hE6, -1, 'hF6, 'hFE);
		put_op(MN_BCC, MD_REL, 8'h90); put_op(MN_BCS, MD_REL, 8'hB0);
		put_op(MN_BEQ, MD_REL, 8'hF0); put_op(MN_BNE, MD_REL, 8'hD0);
		put_op(MN_BMI, MD_REL, 8'h30); put_op(MN_BPL, MD_REL, 8'h10);
		put_op(MN_BVC, MD_REL, 8'h50); put_op(MN_BVS, MD_REL, 8'h70);
		put_op(MN_BIT, MD_ABS, 8'h2C); put_op(MN_BIT, MD_ZP, 8'h24);
		put_op(MN_CPX, MD_IMM, 8'hE0); put_op(MN_CPX, MD_ABS, 8'hEC);
		put_op(MN_CPX, MD_ZP, 8'hE4);
		put_op(MN_CPY, MD_IMM, 8'hC0); put_op(MN_CPY, MD_ABS, 8'hCC);
		put_op(MN_CPY, MD_ZP, 8'hC4);
		put_op(MN_JMP, MD_ABS, 8'h4C); put_op(MN_JMP, MD_IND, 8'h6C);
		put_op(MN_JSR, MD_ABS, 8'h20);
		put_op(MN_LDA, MD_IMMH, 8'hA9); put_op(MN_LDA, MD_IMML, 8'hA9);
		put_op(MN_LDX, MD_IMM, 8'hA2); put_op(MN_LDX, MD_ABS, 8'hAE);
		put_op(MN_LDX, MD_ZP, 8'hA6); put_op(MN_LDX, MD_ABSY, 8'hBE);
		put_op(MN_LDX, MD_ZPY, 8'hB6); put_op(MN_LDX, MD_IMMH, 8'hA2);
		put_op(MN_LDX, MD_IMML, 8'hA2);
		put_op(MN_LDY, MD_IMM, 8'hA0); put_op(MN_LDY, MD_ABS, 8'hAC);
		put_op(MN_LDY, MD_ZP, 8'hA4); put_op(MN_LDY, MD_ZPX, 8'hB4);
		put_op(MN_LDY, MD_ABSX, 8'hBC); put_op(MN_LDY, MD_IMMH, 8'hA0);
		put_op(MN_LDY, MD_IMML, 8'hA0);
		put_op(MN_STX, MD_ABS, 8'h8E); put_op(MN_STX, MD_ZP, 8'h86);
		put_op(MN_STX, MD_ZPY, 8'h96);
		put_op(MN_STY, MD_ABS, 8'h8C); put_op(MN_STY, MD_ZP, 8'h84);
		put_op(MN_STY, MD_ZPX, 8'h94);
		put_op(MN_BRK, MD_IMPL, 8'h00); put_op(MN_CLC, MD_IMPL, 8'h18);
		put_op(MN_CLD, MD_IMPL, 8'hD8); put_op(MN_CLI, MD_IMPL, 8'h58);
		put_op(MN_CLV, MD_IMPL, 8'hB8); put_op(MN_DEX, MD_IMPL, 8'hCA);
		put_op(MN_DEY, MD_IMPL, 8'h88); put_op(MN_INX, MD_IMPL, 8'hE8);
		put_op(MN_INY, MD_IMPL, 8'hC8); put_op(MN_NOP, MD_IMPL, 8'hEA);
		put_op(MN_PHA, MD_IMPL, 8'h48); put_op(MN_PHP, MD_IMPL, 8'h08);
		put_op(MN_PLA, MD_IMPL, 8'h68); put_op(MN_PLP, MD_IMPL, 8'h28);
		put_op(MN_RTI, MD_IMPL, 8'h40); put_op(MN_RTS, MD_IMPL, 8'h60);
		put_op(MN_SEC, MD_IMPL, 8'h38); put_op(MN_SED, MD_IMPL, 8'hF8);
		put_op(MN_SEI, MD_IMPL, 8'h78); put_op(MN_TAX, MD_IMPL, 8'hAA);
		put_op(MN_TAY, MD_IMPL, 8'hA8); put_op(MN_TSX, MD_IMPL, 8'hBA);
		put_op(MN_TXA, MD_IMPL, 8'h8A); put_op(MN_TXS, MD_IMPL, 8'h9A);
		put_op(MN_TYA, MD_IMPL, 8'h98);
	endtask

	// Branches take absolute or zero-page syntax as relative
	function automatic logic resolve_opcode(input logic [5:0] mn, input logic [3:0] md,
			output logic [3:0] kind, output logic [7:0] opc);
		kind = md;
		opc = opcode_rom[mn][md][7:0];
		if (opcode_rom[mn][md][8]) return 1'b1;
		if ((md == MD_ABS || md == MD_ZP) && opcode_rom[mn][MD_REL][8]) begin
			kind = MD_REL;
			opc = opcode_rom[mn][MD_REL][7:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_bytes(input instr_t it);
		logic       hit;
		logic [3:0] kind;
		logic [3:0] k2;
		logic [3:0] zp_mode;
		logic [7:0] opc;
		logic [7:0] o2;
		logic [7:0] b [3];
		logic [1:0] err;
		logic [2:0] fix;
		longint     v;
		longint     off;
		int         n;
		obj_byte_t  ob;
		v = longint'($signed(it.operand_value));
		err = ERR_NONE;
		fix = FIX_NONE;
		b[1] = 8'h00;
		b[2] = 8'h00;
		hit = resolve_opcode(it.mnemonic, it.addr_mode, kind, opc);
		if (!hit || (it.zp_request && it.value_defined && v >= 0 && v < 256)) begin
			if (it.addr_mode <= MD_ABSY) begin
				zp_mode = (it.addr_mode == MD_ABS) ? MD_ZP :
					(it.addr_mode == MD_ABSX) ? MD_ZPX : MD_ZPY;
				if (resolve_opcode(it.mnemonic, zp_mode, k2, o2)) begin
					hit = 1'b1;
					kind = k2;
					opc = o2;
				end
			end
		end
		b[0] = opc;
		if (!hit) begin
			n = 3;
			b[0] = NOP_BYTE;
			b[1] = NOP_BYTE;
			b[2] = NOP_BYTE;
			err = ERR_ILLEGAL;
		end else begin
			case (kind)
				MD_IMPL: n = 1;
				MD_IMMH, MD_IMML: begin
					n = 2;
					if (!it.value_defined) fix = (kind == MD_IMMH) ? FIX_HIGH : FIX_LOW;
					else b[1] = (kind == MD_IMMH) ? it.operand_value[15:8] : it.operand_value[7:0];
				end
				MD_REL: begin
					n = 2;
					off = v - (longint'(it.location) + 2);
					if (!it.value_defined) fix = FIX_BRANCH;
					else if (off < -128 || off > 127) err = ERR_RANGE;
					else b[1] = off[7:0];
				end
				MD_ABS, MD_ABSX, MD_ABSY, MD_IND: begin
					n = 3;
					if (!it.value_defined) fix = FIX_WORD;
					else begin
						b[1] = it.operand_value[7:0];
						b[2] = it.operand_value[15:8];
					end
				end
				default: begin
					n = 2;
					if (!it.value_defined) fix = FIX_BYTE;
					else if (v < -256 || v > 255) err = ERR_RANGE;
					else b[1] = it.operand_value[7:0];
				end
			endcase
		end
		if (int'(it.location) + n > 'h10000) err = ERR_PAST64K;
		for (int i = 0; i < n; i++) begin
			ob.code = b[i];
			ob.last = (i == n - 1);
			ob.err = err;
			ob.fix = fix;
			code_bytes_q.push_back(ob);
		end
	endtask

	function automatic instr_t mk_instr(input logic [5:0] mn, input logic [3:0] md,
			input logic zp, input logic [31:0] val, input logic def, input logic [15:0] loc);
		instr_t it;
		it.mnemonic = mn;
		it.addr_mode = md;
		it.zp_request = zp;
		it.operand_value = val;
		it.value_defined = def;
		it.location = loc;
		return it;
	endfunction

	function automatic logic [3:0] pick_legal_mode(input logic [5:0] mn);
		logic [3:0] modes [$];
		for (int md = 0; md <= MD_IMML; md++)
			if (opcode_rom[mn][md][8]) modes.push_back(md[3:0]);
		if (opcode_rom[mn][MD_REL][8]) begin
			modes.push_back(MD_ABS);
			modes.push_back(MD_ZP);
		end
		return modes[$urandom_range(0, modes.size() - 1)];
	endfunction

	// Mostly legal pairs; values cluster around the range and branch limits
	function automatic instr_t rand_instr();
		instr_t it;
		it.mnemonic = 6'($urandom_range(0, 55));
		if ($urandom_range(0, 6) == 0) it.addr_mode = 4'($urandom_range(0, 13));
		else it.addr_mode = pick_legal_mode(it.mnemonic);
		it.zp_request = 1'($urandom_range(0, 1));
		it.value_defined = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 7) == 0) it.location = 16'($urandom_range('hFFF0, 'hFFFF));
		else it.location = 16'($urandom);
		case ($urandom_range(0, 4))
			0: it.operand_value = $urandom_range(0, 255);
			1: it.operand_value = 32'($urandom_range(0, 600)) - 32'd300;
			2: it.operand_value = 32'(it.location) + 32'd2 + 32'($urandom_range(0, 280))
				- 32'd140;
			3: it.operand_value = $urandom;
			default: it.operand_value = $urandom_range(256, 65535);
		endcase
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_instr(input instr_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0000, it};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_bytes(it);
		@(negedge clk);
	endtask

	task automatic set_idling(input bit on, input int hold);
		// drop the last item so the edge below does not take it again
		s_tvalid <= 1'b0;
		@(posedge clk);
		idle_on = on;
		long_hold = hold;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] byte %0d: %s got 0x%0h, expected 0x%0h", $time, bytes_seen, what,
			got, want);
		mismatches++;
	endtask

	task automatic test_directed();
		send_instr(mk_instr(MN_NOP, MD_IMPL, 1'b0, 32'd0, 1'b1, 16'h0000));
		send_instr(mk_instr(MN_BRK, MD_IMPL, 1'b0, 32'd0, 1'b1, 16'hFFFF));
		send_instr(mk_instr(MN_LDA, MD_IMM, 1'b0, 32'd255, 1'b1, 16'h0200));
		send_instr(mk_instr(MN_CMP, MD_IMM, 1'b1, -32'sd256, 1'b1, 16'h0200));
		send_instr(mk_instr(MN_ADC, MD_IMM, 1'b0, 32'd256, 1'b1, 16'h0300));
		send_instr(mk_instr(MN_ADC, MD_INDY, 1'b0, -32'sd257, 1'b1, 16'h0300));
		send_instr(mk_instr(MN_CPX, MD_IMM, 1'b0, 32'd7, 1'b0, 16'h0400));
		send_instr(mk_instr(MN_LDA, MD_IMMH, 1'b0, 32'h8000_1234, 1'b1, 16'h0400));
		send_instr(mk_instr(MN_LDA, MD_IMML, 1'b0, 32'hFFFF_FFFF, 1'b1, 16'h0400));
		send_instr(mk_instr(MN_LDX, MD_IMML, 1'b0, 32'd0, 1'b0, 16'h0500));
		send_instr(mk_instr(MN_LDY, MD_IMMH, 1'b0, 32'd0, 1'b0, 16'h0500));
		send_instr(mk_instr(MN_JMP, MD_IND, 1'b0, 32'h0000_FFFF, 1'b1, 16'h0600));
		send_instr(mk_instr(MN_JSR, MD_ABS, 1'b1, 32'd0, 1'b0, 16'h0600));
		send_instr(mk_instr(MN_STA, MD_ABS, 1'b1, 32'h7FFF_FFFF, 1'b1, 16'h0700));
		// shrink only for a defined value below 0x100 and a legal zero-page form
		send_instr(mk_instr(MN_LDA, MD_ABS, 1'b1, 32'h80, 1'b1, 16'h0800));
		send_instr(mk_instr(MN_LDA, MD_ABSX, 1'b1, 32'h100, 1'b1, 16'h0800));
		send_instr(mk_instr(MN_JMP, MD_ABS, 1'b1, 32'h10, 1'b1, 16'h0800));
		send_instr(mk_instr(MN_LDX, MD_ABSY, 1'b1, 32'h05, 1'b1, 16'h0800));
		// illegal pair rescued by its zero-page form, then out of byte range
		send_instr(mk_instr(MN_STY, MD_ABSX, 1'b0, 32'h1234, 1'b1, 16'h0900));
		send_instr(mk_instr(MN_BNE, MD_REL, 1'b0, 32'h1000 + 2 + 127, 1'b1, 16'h1000));
		send_instr(mk_instr(MN_BPL, MD_REL, 1'b0, 32'h1000 + 2 - 128, 1'b1, 16'h1000));
		send_instr(mk_instr(MN_BMI, MD_REL, 1'b0, 32'h1000 + 2 + 128, 1'b1, 16'h1000));
		send_instr(mk_instr(MN_BEQ, MD_ABS, 1'b0, 32'd0, 1'b0, 16'h1000));
		send_instr(mk_instr(MN_BCC, MD_ZP, 1'b1, 32'h20, 1'b1, 16'h0010));
		send_instr(mk_instr(MN_JSR, MD_IMPL, 1'b0, 32'd0, 1'b1, 16'h1100));
		send_instr(mk_instr(MN_BAD, MD_BAD, 1'b1, 32'd0, 1'b1, 16'h1100));
		send_instr(mk_instr(MN_LDA, MD_IMM, 1'b0, 32'd0, 1'b1, 16'hFFFF));
		send_instr(mk_instr(MN_TAX, MD_ZPY, 1'b0, 32'd0, 1'b1, 16'hFFFE));
	endtask

	task automatic test_random_with_gaps();
		set_idling(1'b1, 0);
		repeat (92) send_instr(rand_instr());
	endtask

	task automatic test_random_back_to_back();
		set_idling(1'b0, 0);
		repeat (40) send_instr(rand_instr());
	endtask

	// Receiver stops for a long stretch while items keep coming
	task automatic test_output_stall();
		set_idling(1'b0, 300);
		repeat (20) send_instr(rand_instr());
		set_idling(1'b1, 0);
	endtask

	initial begin
		fill_opcode_rom();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_with_gaps();
		test_random_back_to_back();
		test_output_stall();
		s_tvalid <= 1'b0;
		while (code_bytes_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				m_tready <= 1'b0;
				repeat (long_hold) @(negedge clk);
				long_hold = 0;
			end
			stall = idle_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		obj_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (code_bytes_q.size() == 0) begin
				report_mismatch("unexpected byte", 32'(m_tdata), 32'd0);
			end else begin
				want = code_bytes_q.pop_front();
				if (m_tdata !== want.code)
					report_mismatch("code_byte", 32'(m_tdata), 32'(want.code));
				if (m_tlast !== want.last)
					report_mismatch("last_byte", 32'(m_tlast), 32'(want.last));
				if (m_tuser[1:0] !== want.err)
					report_mismatch("error_code", 32'(m_tuser[1:0]), 32'(want.err));
				if (m_tuser[4:2] !== want.fix)
					report_mismatch("fixup_kind", 32'(m_tuser[4:2]), 32'(want.fix));
			end
			bytes_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
